>>> rtl/core/adcmed_pkg.sv
package adcmed_pkg;

  // Group size and sample width
  localparam int SAMPLES  = 9;
  localparam int SAMPLE_W = 12;

  // Index into the group buffer
  localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // Last slot of a group and the slot that holds the (lower) median once sorted
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);
  localparam logic [IDX_W-1:0] MID_IDX  = IDX_W'((SAMPLES - 1) / 2);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // Sequencer command to the sorted buffer
  typedef struct packed {
    logic shift;  // move entry pos-1 up into pos
    logic place;  // write the new sample into pos
    idx_t pos;    // current hole in the sorted buffer
  } adcmed_ctl_t;

endpackage

>>> rtl/core/adc_median_of_n_filter.sv
// Median filter: each sample is insertion-sorted into the group buffer by one
// compare-and-shift step per cycle, a single step shared over the whole buffer.
// Busy stays high while a sample moves down from its group slot to its sorted
// place, and through the result state for the group-completing sample; a new
// sample is taken only while idle, so one sample is finished before the next.
// The result state registers the median and strobes out_valid; results cannot
// be stalled. Synchronous reset empties the group.
module adc_median_of_n_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  adcmed_pkg::sample_t in_sample,
  output logic                out_valid,
  output adcmed_pkg::sample_t out_median_value
);
  import adcmed_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t      state_r;
  idx_t        fill_r;
  idx_t        pos_r;
  sample_t     sample_r;
  logic        out_valid_r;
  sample_t     out_median_value_r;
  adcmed_ctl_t ctl;
  logic        gt;
  sample_t     mid;

  // Drive the shared compare/shift step
  always_comb begin
    ctl.pos   = pos_r;
    ctl.shift = (state_r == ST_SCAN) && gt;
    ctl.place = (state_r == ST_SCAN) && !gt;
  end

  adcmed_buf u_buf (
    .clk    (clk),
    .ctl    (ctl),
    .sample (sample_r),
    .gt     (gt),
    .mid    (mid)
  );

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            sample_r <= in_sample;
            pos_r    <= fill_r;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (gt) begin
            pos_r <= pos_r - idx_t'(1);
          end else if (fill_r == LAST_IDX) begin
            fill_r  <= '0;
            state_r <= ST_EMIT;
          end else begin
            fill_r  <= fill_r + idx_t'(1);
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          out_valid_r        <= 1'b1;
          out_median_value_r <= mid;
          state_r            <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_median_value = out_median_value_r;

`ifndef ASSERT_OFF
  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // A transfer makes the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer did not start the sort step");

  // Fill count never passes the last slot
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LAST_IDX)
    else $error("fill count out of range");

  // The hole never sits above the current fill position
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pos_r <= fill_r))
    else $error("insertion position above fill count");
`endif

endmodule

>>> rtl/core/adcmed_buf.sv
module adcmed_buf (
  input  logic                 clk,
  input  adcmed_pkg::adcmed_ctl_t ctl,
  input  adcmed_pkg::sample_t  sample,
  output logic                 gt,
  output adcmed_pkg::sample_t  mid
);
  import adcmed_pkg::*;

  sample_t buf_r [SAMPLES];
  idx_t    prev_idx;
  sample_t prev_val;

  // Look at the entry just below the hole; none exists at slot zero
  assign prev_idx = (ctl.pos == '0) ? '0 : ctl.pos - idx_t'(1);
  assign prev_val = buf_r[prev_idx];
  assign gt       = (ctl.pos != '0) && (prev_val > sample);
  assign mid      = buf_r[MID_IDX];

  // Shift the larger entry up, or drop the sample into the hole
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      buf_r[ctl.pos] <= prev_val;
    end else if (ctl.place) begin
      buf_r[ctl.pos] <= sample;
    end
  end

endmodule

>>> verif/adc_median_of_n_filter_tb.sv
module adc_median_of_n_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adcmed_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RAND_ITEMS  = 550;
  localparam int CALM_TAIL   = 100;
  localparam int DIR_ROWS    = 25;

  // One directed row: sample to send, and the median typed in for rows that close a group
  typedef struct packed {
    sample_t smp;
    logic    typed;
    sample_t med;
  } stim_row_t;

  // Shape of the samples inside one random group
  typedef enum int {
    GRP_RANDOM,
    GRP_ASCEND,
    GRP_DESCEND,
    GRP_CLUSTER,
    GRP_EXTREME
  } grp_kind_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    start     = 1'b0;
  sample_t in_sample = '0;
  logic    busy;
  logic    out_valid;
  sample_t out_median_value;

  // Predictor state: samples of the open group and how many are in it
  sample_t group_buf [SAMPLES];
  int      group_fill = 0;

  // Medians still owed by the block, oldest first
  sample_t median_q [$];

  // Typed-in median for the row being driven
  bit      pin_valid = 1'b0;
  sample_t pin_med   = '0;

  int xfer_cnt   = 0;
  int median_cnt = 0;
  int err_cnt    = 0;
  int quiet_cyc  = 0;
  int sent       = 0;

  stim_row_t dir_tbl [DIR_ROWS] = '{
    // group of all zeros right after reset
    '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
    '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
    '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'h000, 1'b1, 12'h000},
    // five full-scale against four zeros: median lands on full scale
    '{12'hFFF, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000},
    '{12'h000, 1'b0, 12'h000}, '{12'hFFF, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000},
    '{12'hFFF, 1'b0, 12'h000}, '{12'h000, 1'b0, 12'h000}, '{12'hFFF, 1'b1, 12'hFFF},
    // mixed bit patterns (alternating, edge, arbitrary); this group is closed by the random part
    '{12'hAAA, 1'b0, 12'h000}, '{12'h555, 1'b0, 12'h000}, '{12'h800, 1'b0, 12'h000},
    '{12'h001, 1'b0, 12'h000}, '{12'h7FF, 1'b0, 12'h000}, '{12'hFFE, 1'b0, 12'h000},
    '{12'h123, 1'b0, 12'h000}
  };

  adc_median_of_n_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_median_value (out_median_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Add one sample to the open group; on the last slot sort and report the lower median
  function automatic void fold_sample(input sample_t s, output bit done, output sample_t med);
    sample_t srt [SAMPLES];
    sample_t t;
    int      i;
    int      j;
    group_buf[group_fill] = s;
    done = 1'b0;
    med  = '0;
    if (group_fill + 1 < SAMPLES) begin
      group_fill = group_fill + 1;
    end else begin
      srt = group_buf;
      for (i = 1; i < SAMPLES; i++) begin
        t = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > t) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = t;
      end
      med        = srt[(SAMPLES - 1) / 2];
      done       = 1'b1;
      group_fill = 0;
    end
  endfunction

  // Check results, predict on each input transfer, and watch for a stuck block
  always @(posedge clk) begin
    bit      done;
    sample_t med;
    sample_t want;
    if (rst_n) begin
      quiet_cyc++;
      if (out_valid) begin
        quiet_cyc = 0;
        median_cnt++;
        if (median_q.size() == 0) begin
          $display("%0t: unexpected median, expected none, actual %0d",
                   $time, out_median_value);
          err_cnt++;
        end else begin
          want = median_q.pop_front();
          if (out_median_value !== want) begin
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, want, out_median_value);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        quiet_cyc = 0;
        xfer_cnt++;
        fold_sample(in_sample, done, med);
        if (done) median_q.push_back(pin_valid ? pin_med : med);
      end
      if (quiet_cyc >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one sample and hold it until the block takes it
  task automatic send_sample(input sample_t s, input bit typed, input sample_t med);
    @(negedge clk);
    start     <= 1'b1;
    in_sample <= s;
    pin_valid  = typed;
    pin_med    = med;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Hold start low with junk on the sample port; n sets the length of the gap
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      in_sample <= sample_t'($urandom);
    end
  endtask

  initial begin
    grp_kind_t kind;
    sample_t   vals [SAMPLES];
    sample_t   base;
    bit        bursty;
    bit        drained;
    int        k;

    drained = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back
    foreach (dir_tbl[r]) send_sample(dir_tbl[r].smp, dir_tbl[r].typed, dir_tbl[r].med);

    // Random groups with a shape picked per group
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = grp_kind_t'($urandom_range(0, 4));
      base = sample_t'($urandom_range(0, 4092));
      for (k = 0; k < SAMPLES; k++) begin
        case (kind)
          GRP_ASCEND:  vals[k] = sample_t'(k * 455 + $urandom_range(0, 50));
          GRP_DESCEND: vals[k] = sample_t'(4095 - k * 455 - $urandom_range(0, 50));
          GRP_CLUSTER: vals[k] = base + sample_t'($urandom_range(0, 3));
          GRP_EXTREME: vals[k] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          default:     vals[k] = sample_t'($urandom_range(0, 4095));
        endcase
      end

      // Once, midway, let every owed median come out before going on
      if (!drained && sent >= RAND_ITEMS / 2) begin
        drained = 1'b1;
        @(negedge clk);
        start <= 1'b0;
        while (median_q.size() != 0) @(negedge clk);
      end

      bursty = ($urandom_range(0, 2) != 0) && (sent < RAND_ITEMS - CALM_TAIL);
      for (k = 0; k < SAMPLES; k++) begin
        if (bursty && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
        send_sample(vals[k], 1'b0, '0);
      end
    end

    hold_off(1);
    while (median_q.size() != 0) @(posedge clk);
    repeat (SAMPLES + 4) @(posedge clk);

    if (median_q.size() != 0) begin
      $display("%0t: %0d medians never arrived", $time, median_q.size());
      err_cnt++;
    end
    $display("Covered %0d sample transfers and %0d group medians: extremes, equal runs,",
             xfer_cnt, median_cnt);
    $display("sorted and reversed groups, random sender gaps and one full drain pause.");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/adcmed_pkg.sv
rtl/core/adcmed_buf.sv
rtl/core/adc_median_of_n_filter.sv
verif/adc_median_of_n_filter_tb.sv
